@@ src/i2c_master_prefixed_write_sequencer_assert.svh @@
// Assertion macros used by the write sequencer FSM module
`ifndef I2C_MASTER_PREFIXED_WRITE_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_PREFIXED_WRITE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define I2CMPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define I2CMPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/i2cmps_pkg.sv @@
// Types and constants of the prefixed I2C master write sequencer
`timescale 1ns / 1ps
`default_nettype none
package i2cmps_pkg;

	// Default parameter values
	localparam int unsigned MAX_LENGTH_DEF = 255;
	localparam int unsigned POLL_WIDTH_DEF = 16;

	// Highest legal 7-bit target address
	localparam logic [7:0] ADDR_MAX = 8'h7F;

	// Reset value of the poll limit register
	localparam logic [15:0] POLL_LIMIT_RST = 16'hFFFF;

	// Transfer phases
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_BUS    = 3'd1,
		PH_START  = 3'd2,
		PH_ADDR   = 3'd3,
		PH_PREFIX = 3'd4,
		PH_DATA   = 3'd5,
		PH_FINISH = 3'd6
	} phase_t;

	// Bus controller actions requested of the host
	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_CLEAR   = 3'd1,
		ACT_START   = 3'd2,
		ACT_WRITE   = 3'd3,
		ACT_READCLR = 3'd4,
		ACT_ABORT   = 3'd5
	} action_t;

	// Input beat: a command plus one status poll
	typedef struct packed {
		logic       command;
		logic [7:0] target_address;
		logic [7:0] prefix_byte;
		logic [7:0] transfer_length;
		logic [7:0] data_byte;
		logic       flag_start_sent;
		logic       flag_address_sent;
		logic       flag_tx_empty;
		logic       flag_byte_finished;
		logic       error_pending;
		logic       bus_busy;
	} item_t;

	// Result beat
	typedef struct packed {
		action_t    action;
		logic [7:0] action_byte;
		logic       finished;
		logic       succeeded;
		logic       active;
	} result_t;

endpackage
`default_nettype wire

@@ src/i2cmps_in_stage.sv @@
// Input register of the write sequencer with its stall logic
`timescale 1ns / 1ps
`default_nettype none
module i2cmps_in_stage (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	output logic                cmd_stall,
	input  i2cmps_pkg::item_t   cmd_data,
	input  wire                 advance,
	output logic                valid_s1,
	output i2cmps_pkg::item_t   item_s1
);

	// Hold off a new beat only while the held one cannot move on
	assign cmd_stall = valid_s1 & ~advance;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1 <= cmd_data;
		end
	end

endmodule
`default_nettype wire

@@ src/i2cmps_fsm.sv @@
// Transfer state and one-poll step logic of the write sequencer
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_prefixed_write_sequencer_assert.svh"
module i2cmps_fsm #(
	parameter int unsigned MAX_LENGTH = i2cmps_pkg::MAX_LENGTH_DEF,
	parameter int unsigned POLL_WIDTH = i2cmps_pkg::POLL_WIDTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_wr_en,
	input  wire  [15:0]         cfg_wr_data,
	input  wire                 step,
	input  i2cmps_pkg::item_t   item_s1,
	output i2cmps_pkg::result_t result
);

	// Length cap as seen by an 8-bit length field
	localparam logic [7:0] LEN_CAP = (MAX_LENGTH > 255) ? 8'd255 : 8'(MAX_LENGTH);

	logic [15:0]              poll_limit_q;
	i2cmps_pkg::phase_t       phase_q, phase_d;
	logic [POLL_WIDTH-1:0]    polls_left_q, polls_left_d;
	logic [7:0]               bytes_sent_q, bytes_sent_d;
	logic [6:0]               held_address_q, held_address_d;
	logic [7:0]               held_prefix_q, held_prefix_d;
	logic [7:0]               held_length_q, held_length_d;

	// Poll limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= i2cmps_pkg::POLL_LIMIT_RST;
		end else if (cfg_wr_en) begin
			poll_limit_q <= cfg_wr_data;
		end
	end

	// State registers, updated once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= i2cmps_pkg::PH_IDLE;
			polls_left_q   <= '0;
			bytes_sent_q   <= '0;
			held_address_q <= '0;
			held_prefix_q  <= '0;
			held_length_q  <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			polls_left_q   <= polls_left_d;
			bytes_sent_q   <= bytes_sent_d;
			held_address_q <= held_address_d;
			held_prefix_q  <= held_prefix_d;
			held_length_q  <= held_length_d;
		end
	end

	// Next state and result for the beat in the input register
	always_comb begin
		logic                  flag;
		logic                  spent;
		logic [POLL_WIDTH-1:0] armed;
		logic [POLL_WIDTH-1:0] dec;
		logic [7:0]            sent_inc;
		logic [7:0]            len_sat;

		armed    = POLL_WIDTH'(poll_limit_q);
		spent    = (polls_left_q <= POLL_WIDTH'(1));
		dec      = polls_left_q - POLL_WIDTH'(1);
		sent_inc = bytes_sent_q + 8'd1;
		len_sat  = (item_s1.transfer_length > LEN_CAP) ? LEN_CAP : item_s1.transfer_length;

		phase_d        = phase_q;
		polls_left_d   = polls_left_q;
		bytes_sent_d   = bytes_sent_q;
		held_address_d = held_address_q;
		held_prefix_d  = held_prefix_q;
		held_length_d  = held_length_q;

		result.action      = i2cmps_pkg::ACT_NONE;
		result.action_byte = 8'd0;
		result.finished    = 1'b0;
		result.succeeded   = 1'b0;

		// Flag awaited by the current phase
		case (phase_q)
			i2cmps_pkg::PH_START:  flag = item_s1.flag_start_sent;
			i2cmps_pkg::PH_ADDR:   flag = item_s1.flag_address_sent;
			i2cmps_pkg::PH_PREFIX: flag = item_s1.flag_tx_empty;
			i2cmps_pkg::PH_DATA:   flag = item_s1.flag_tx_empty;
			i2cmps_pkg::PH_FINISH: flag = item_s1.flag_byte_finished;
			default:               flag = 1'b0;
		endcase

		case (phase_q)
			i2cmps_pkg::PH_IDLE: begin
				if (item_s1.command) begin
					if (item_s1.target_address > i2cmps_pkg::ADDR_MAX) begin
						result.finished = 1'b1;
					end else begin
						held_address_d = item_s1.target_address[6:0];
						held_prefix_d  = item_s1.prefix_byte;
						held_length_d  = len_sat;
						bytes_sent_d   = 8'd0;
						phase_d        = i2cmps_pkg::PH_BUS;
						polls_left_d   = armed;
						result.action  = i2cmps_pkg::ACT_CLEAR;
					end
				end
			end
			i2cmps_pkg::PH_BUS: begin
				// a start while busy is ignored; busy-bus timeout ends without abort
				if (!item_s1.command) begin
					if (!item_s1.bus_busy) begin
						phase_d       = i2cmps_pkg::PH_START;
						polls_left_d  = armed;
						result.action = i2cmps_pkg::ACT_START;
					end else if (spent) begin
						polls_left_d    = '0;
						phase_d         = i2cmps_pkg::PH_IDLE;
						result.finished = 1'b1;
					end else begin
						polls_left_d = dec;
					end
				end
			end
			i2cmps_pkg::PH_START, i2cmps_pkg::PH_ADDR, i2cmps_pkg::PH_PREFIX,
			i2cmps_pkg::PH_DATA, i2cmps_pkg::PH_FINISH: begin
				if (!item_s1.command) begin
					if (!flag) begin
						// error wins over the poll count, leaving the count as is
						if (item_s1.error_pending) begin
							phase_d         = i2cmps_pkg::PH_IDLE;
							result.action   = i2cmps_pkg::ACT_ABORT;
							result.finished = 1'b1;
						end else if (spent) begin
							polls_left_d    = '0;
							phase_d         = i2cmps_pkg::PH_IDLE;
							result.action   = i2cmps_pkg::ACT_ABORT;
							result.finished = 1'b1;
						end else begin
							polls_left_d = dec;
						end
					end else begin
						case (phase_q)
							i2cmps_pkg::PH_START: begin
								phase_d            = i2cmps_pkg::PH_ADDR;
								polls_left_d       = armed;
								result.action      = i2cmps_pkg::ACT_WRITE;
								result.action_byte = {held_address_q, 1'b0};
							end
							i2cmps_pkg::PH_ADDR: begin
								phase_d       = i2cmps_pkg::PH_PREFIX;
								polls_left_d  = armed;
								result.action = i2cmps_pkg::ACT_READCLR;
							end
							i2cmps_pkg::PH_PREFIX: begin
								phase_d = (held_length_q == 8'd0) ? i2cmps_pkg::PH_FINISH
									: i2cmps_pkg::PH_DATA;
								polls_left_d       = armed;
								result.action      = i2cmps_pkg::ACT_WRITE;
								result.action_byte = held_prefix_q;
							end
							i2cmps_pkg::PH_DATA: begin
								bytes_sent_d = sent_inc;
								phase_d = (sent_inc >= held_length_q) ? i2cmps_pkg::PH_FINISH
									: i2cmps_pkg::PH_DATA;
								polls_left_d       = armed;
								result.action      = i2cmps_pkg::ACT_WRITE;
								result.action_byte = item_s1.data_byte;
							end
							default: begin
								// byte finished: STOP, success
								phase_d          = i2cmps_pkg::PH_IDLE;
								result.finished  = 1'b1;
								result.succeeded = 1'b1;
							end
						endcase
					end
				end
			end
			default: begin
				// unused encoding falls back to idle
				if (!item_s1.command) begin
					phase_d = i2cmps_pkg::PH_IDLE;
				end
			end
		endcase

		result.active = (phase_d != i2cmps_pkg::PH_IDLE);
	end

	// Checks
	`I2CMPS_ASSERT_IMPL(a_ok_is_end, clk, arst_n, result.succeeded,
		result.finished && (result.action == i2cmps_pkg::ACT_NONE),
		"success reported without a plain finish")
	`I2CMPS_ASSERT_IMPL(a_end_leaves_idle, clk, arst_n, result.finished, !result.active,
		"finished transfer still marked active")
	`I2CMPS_ASSERT_NEXT(a_idle_poll_stays, clk, arst_n,
		step && (phase_q == i2cmps_pkg::PH_IDLE) && !item_s1.command,
		phase_q == i2cmps_pkg::PH_IDLE, "poll while idle left idle")
	`I2CMPS_ASSERT_IMPL(a_data_count, clk, arst_n, phase_q == i2cmps_pkg::PH_DATA,
		bytes_sent_q < held_length_q, "data phase with all bytes already sent")

endmodule
`default_nettype wire

@@ src/i2cmps_out_stage.sv @@
// Result register of the write sequencer
`timescale 1ns / 1ps
`default_nettype none
module i2cmps_out_stage (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   valid_s1,
	input  i2cmps_pkg::result_t   result,
	output logic                  advance,
	output logic                  rsp_valid,
	input  wire                   rsp_stall,
	output i2cmps_pkg::result_t   rsp_data
);

	logic                rsp_valid_q;
	i2cmps_pkg::result_t rsp_data_q;

	// Register can take a new beat when empty or being drained
	assign advance   = ~rsp_valid_q | ~rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_data_q <= result;
		end
	end

endmodule
`default_nettype wire

@@ src/i2c_master_prefixed_write_sequencer.sv @@
// Top level of the prefixed I2C master write sequencer
`timescale 1ns / 1ps
`default_nettype none
// Steps a polled I2C master write (START, address, one prefix byte, data bytes,
// STOP) one status poll per beat: a command beat starts a transfer and each
// following poll beat returns the bus-controller action to take. Every input
// beat gives exactly one result beat. Throughput is one beat per clock while
// the result is not stalled. The whole transfer step of a beat is done by a
// single layer of state logic between the input register and the result
// register, which offers the result. The input stalls only while both
// registers hold beats and the result is stalled. The user must set
// poll_limit through cfg_wr_en/cfg_wr_data while no transfer is in flight;
// the block does not enforce this. No initialization pass follows reset.
module i2c_master_prefixed_write_sequencer #(
	parameter int unsigned MAX_LENGTH = i2cmps_pkg::MAX_LENGTH_DEF,
	parameter int unsigned POLL_WIDTH = i2cmps_pkg::POLL_WIDTH_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_wr_en,
	input  wire  [15:0]           cfg_wr_data,
	input  wire                   cmd_valid,
	output logic                  cmd_stall,
	input  i2cmps_pkg::item_t     cmd_data,
	output logic                  rsp_valid,
	input  wire                   rsp_stall,
	output i2cmps_pkg::result_t   rsp_data
);

	logic                valid_s1;
	i2cmps_pkg::item_t   item_s1;
	logic                advance;
	i2cmps_pkg::result_t result;

	i2cmps_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	i2cmps_fsm #(
		.MAX_LENGTH (MAX_LENGTH),
		.POLL_WIDTH (POLL_WIDTH)
	) u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (advance & valid_s1),
		.item_s1     (item_s1),
		.result      (result)
	);

	i2cmps_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result    (result),
		.advance   (advance),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule
`default_nettype wire
